FILE: rtl/gam_pkg.sv
`timescale 1ns / 1ps

package gam_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS   = 13;
  localparam int FRACTION_BITS = 8;
  localparam int KEY_W         = 4;
  localparam int PERIOD_W      = 16;
  localparam int SCALE_W       = 5;
  localparam int OFFSET_W      = 12;
  localparam int GAIN_W        = 16;
  localparam int GAIN_FRAC     = 16;
  localparam int MAG_W         = 26;
  localparam int ACC_W         = 20;
  localparam int CFG_W         = 16;
  localparam int CFG_ADDR_W    = 2;

  // Datapath widths
  localparam int PROD_W  = SAMPLE_BITS + SCALE_W + 1;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int ABS_W   = SAMPLE_BITS + SCALE_W;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int RAD_W   = SUM_W + 2 * FRACTION_BITS;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int ITER_W  = $clog2(ROOT_W);
  localparam int CMP_W   = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;
  localparam int SAFE_W  = 64 - 2 * FRACTION_BITS;
  localparam int GPROD_W = MAG_W + GAIN_W;

  // Stream widths
  localparam int IN_FIELDS_W  = KEY_W + 3 * SAMPLE_BITS;
  localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = MAG_W + ACC_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Saturation limits
  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Push-button codes
  localparam logic [KEY_W-1:0] KEY_START = 4'd1;
  localparam logic [KEY_W-1:0] KEY_STOP  = 4'd2;
  localparam logic [KEY_W-1:0] KEY_HALT  = 4'd4;

  // Register defaults
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 5'd4;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd981;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd643;

  // Axis sequencer of the sum-of-squares unit: three loads, one trailing add
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_LAST = 2'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_OFFSET = 2'd2,
    CFG_GAIN   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_ROOT,
    ST_GAIN,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/gam_sumsq.sv
`timescale 1ns / 1ps

module gam_sumsq
  import gam_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic [SCALE_W-1:0]            lsb_scale,
  input  logic [OFFSET_W-1:0]           gravity_offset_mg,
  output logic                          done,
  output logic [SUM_W-1:0]              sum
);

  logic signed [SAMPLE_BITS-1:0] axis_r [3];
  logic [1:0]                    cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [ABS_W-1:0]              abs_r;
  logic [SUM_W-1:0]              sum_r;

  logic signed [SCALE_W:0]  scale_s;
  logic signed [PROD_W-1:0] prod;
  logic [DIFF_W-1:0]        diff;
  logic [DIFF_W-1:0]        neg;
  logic [ABS_W-1:0]         abs_nxt;
  logic [SQ_W-1:0]          sq;
  logic [SUM_W-1:0]         sum_nxt;

  always_comb begin
    scale_s = {1'b0, lsb_scale};
    prod    = PROD_W'(axis_r[0]) * PROD_W'(scale_s);
    // Z carries the gravity offset
    diff    = {{(DIFF_W - PROD_W){prod[PROD_W-1]}}, prod}
              - ((cnt_r == AXIS_Z) ? DIFF_W'(gravity_offset_mg) : '0);
    neg     = '0 - diff;
    abs_nxt = diff[DIFF_W-1] ? ABS_W'(neg) : ABS_W'(diff);
    sq      = SQ_W'(abs_r) * SQ_W'(abs_r);
    sum_nxt = sum_r + SUM_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == AXIS_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Axes shift past one scaler; the square of each lands in the sum in the cycle after its load
  always_ff @(posedge clk) begin
    if (start) begin
      axis_r[0] <= accel_x;
      axis_r[1] <= accel_y;
      axis_r[2] <= accel_z;
      sum_r     <= '0;
    end else if (busy_r) begin
      axis_r[0] <= axis_r[1];
      axis_r[1] <= axis_r[2];
      axis_r[2] <= axis_r[0];
      abs_r     <= abs_nxt;
      if (cnt_r != '0) begin
        sum_r <= sum_nxt;
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

FILE: rtl/gam_isqrt.sv
`timescale 1ns / 1ps

module gam_isqrt
  import gam_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  // One root bit per cycle: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ITER_W'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/gated_acceleration_magnitude_top.sv
`timescale 1ns / 1ps

// Channel  | Ports                              | Carries
// ---------+------------------------------------+-------------------------------------
// input    | in_tvalid, in_tready, in_tdata     | key_state, accel_x, accel_y, accel_z
// result   | out_tvalid, out_tready, out_tdata  | magnitude_mg_q8, accel_ms2_q8
// config   | cfg_we, cfg_addr, cfg_wdata        | period, scale, offset, gain
//
// A tick that produces no result leaves the block idle. A tick that produces a result
// passes through the shared squarer and the bit-serial root loop, then hand-off, gain
// multiply and output load.
// One result register separates the sides; a stalled result holds while the next
// tick is taken. Reset is synchronous, active low, and restores register defaults.

module gated_acceleration_magnitude_top
  import gam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // key_state, accel_x, accel_y, accel_z, pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // magnitude_mg_q8, accel_ms2_q8, pad
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [PERIOD_W-1:0] period_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [GAIN_W-1:0]   gain_r;

  state_t              state_r, state_nxt;
  logic                measuring_r, measuring_nxt;
  logic                halted_r, halted_nxt;
  logic [PERIOD_W-1:0] elapsed_r, elapsed_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [MAG_W-1:0]    mag_r;
  logic [GPROD_W-1:0]  prod_r;
  logic [MAG_W-1:0]    out_mag_r;
  logic [ACC_W-1:0]    out_acc_r;

  logic                          in_xfer;
  logic [KEY_W-1:0]              key;
  logic signed [SAMPLE_BITS-1:0] ax, ay, az;
  logic                          meas;
  logic [PERIOD_W-1:0]           inc;
  logic                          sum_start, sum_done;
  logic [SUM_W-1:0]              sum;
  logic                          root_start, root_done;
  logic [ROOT_W-1:0]             root;
  logic                          rad_ovf;
  logic [MAG_W-1:0]              mag_nxt;
  logic                          acc_ovf;
  logic [ACC_W-1:0]              acc_nxt;
  logic                          out_load;

  assign key = in_tdata[KEY_W-1:0];
  assign ax  = $signed(in_tdata[KEY_W +: SAMPLE_BITS]);
  assign ay  = $signed(in_tdata[KEY_W + SAMPLE_BITS +: SAMPLE_BITS]);
  assign az  = $signed(in_tdata[KEY_W + 2 * SAMPLE_BITS +: SAMPLE_BITS]);

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      scale_r  <= SCALE_RST;
      offset_r <= OFFSET_RST;
      gain_r   <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_SCALE:  scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
        CFG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  gam_sumsq u_sumsq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (sum_start),
    .accel_x           (ax),
    .accel_y           (ay),
    .accel_z           (az),
    .lsb_scale         (scale_r),
    .gravity_offset_mg (offset_r),
    .done              (sum_done),
    .sum               (sum)
  );

  gam_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (RAD_W'(sum) << (2 * FRACTION_BITS)),
    .done     (root_done),
    .root     (root)
  );

  // Saturate if shifted sum leaves 64 bits or root its field; also on acc overflow
  always_comb begin
    rad_ovf = (SUM_W > SAFE_W) && ((sum >> SAFE_W) != '0);
    mag_nxt = (rad_ovf || (CMP_W'(root) > CMP_W'(MAG_MAX))) ? MAG_MAX : MAG_W'(root);
    acc_ovf = (prod_r >> (GAIN_FRAC + ACC_W)) != '0;
    acc_nxt = acc_ovf ? ACC_MAX : prod_r[GAIN_FRAC +: ACC_W];
  end

  always_comb begin
    state_nxt     = state_r;
    measuring_nxt = measuring_r;
    halted_nxt    = halted_r;
    elapsed_nxt   = elapsed_r;
    sum_start     = 1'b0;
    root_start    = 1'b0;
    out_load      = 1'b0;
    meas          = measuring_r;
    inc           = (elapsed_r != '1) ? (elapsed_r + PERIOD_W'(1)) : elapsed_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && !halted_r) begin
          if (key == KEY_STOP) begin
            meas = 1'b0;
          end
          if (key == KEY_START) begin
            meas = 1'b1;
          end
          measuring_nxt = meas;
          if (meas && (inc > period_r)) begin
            elapsed_nxt = '0;
            sum_start   = 1'b1;
            state_nxt   = ST_SUM;
          end else begin
            elapsed_nxt = inc;
          end
          if (key == KEY_HALT) begin
            halted_nxt = 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          root_start = 1'b1;
          state_nxt  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Wait for the result register to free up
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      measuring_r <= 1'b0;
      halted_r    <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      measuring_r <= measuring_nxt;
      halted_r    <= halted_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ROOT && root_done) begin
      mag_r <= mag_nxt;
    end
    if (state_r == ST_GAIN) begin
      prod_r <= GPROD_W'(mag_r) * GPROD_W'(gain_r);
    end
    if (out_load) begin
      out_mag_r <= mag_r;
      out_acc_r <= acc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_acc_r, out_mag_r});

endmodule
